### src/atd_pkg.sv
`default_nettype none

package atd_pkg;

    // fixed-point constants
    localparam logic signed [31:0] ONE_Q30       = 32'sd1073741824;
    localparam logic signed [34:0] PI_Q30        = 35'sd3373259426;
    localparam logic signed [31:0] HALF_PI_Q29   = 32'sd843314857;
    localparam logic        [34:0] ANGLE_MAX_Q29 = 35'd1686629713;
    localparam logic        [63:0] ONE_Q60       = 64'h1000_0000_0000_0000;

    // sequencer step counts (last count value of each loop)
    localparam logic [4:0] SQRT_LAST   = 5'd31;
    localparam logic [4:0] DIV_LAST    = 5'd29;
    localparam logic [4:0] CORDIC_LAST = 5'd29;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_STORE,
        OP_CAPTURE,
        OP_SQ_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_LEN_SAVE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_SAVE,
        OP_COS_INIT,
        OP_ATAN_INIT,
        OP_ATAN_STEP,
        OP_ATAN_SAVE,
        OP_OUT
    } atd_op_t;

    // angle slots, carried in the col field for atan operations
    localparam logic [1:0] ANG_Y = 2'd0;
    localparam logic [1:0] ANG_X = 2'd1;
    localparam logic [1:0] ANG_Z = 2'd2;

    typedef struct packed {
        atd_op_t    op;
        logic [1:0] col;
        logic [1:0] elem;
        logic [4:0] step;
    } atd_cmd_t;

    typedef struct packed {
        logic invalid;
        logic out_busy;
    } atd_status_t;

    // arctangent of 2^-i in Q2.30, truncated
    function automatic logic [29:0] atd_atan(input logic [4:0] i);
        logic [29:0] v;
        begin
            case (i)
                5'd0:  v = 30'd843314856;
                5'd1:  v = 30'd497837829;
                5'd2:  v = 30'd263043836;
                5'd3:  v = 30'd133525158;
                5'd4:  v = 30'd67021686;
                5'd5:  v = 30'd33543515;
                5'd6:  v = 30'd16775850;
                5'd7:  v = 30'd8388437;
                5'd8:  v = 30'd4194282;
                5'd9:  v = 30'd2097149;
                5'd10: v = 30'd1048575;
                5'd11: v = 30'd524287;
                5'd12: v = 30'd262143;
                5'd13: v = 30'd131071;
                5'd14: v = 30'd65535;
                5'd15: v = 30'd32767;
                5'd16: v = 30'd16383;
                5'd17: v = 30'd8191;
                5'd18: v = 30'd4095;
                5'd19: v = 30'd2047;
                5'd20: v = 30'd1023;
                5'd21: v = 30'd511;
                5'd22: v = 30'd255;
                5'd23: v = 30'd127;
                5'd24: v = 30'd63;
                5'd25: v = 30'd31;
                5'd26: v = 30'd15;
                5'd27: v = 30'd7;
                5'd28: v = 30'd3;
                5'd29: v = 30'd1;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

### src/atd_ctrl.sv
`default_nettype none

module atd_ctrl
    import atd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    output logic             in_ready,
    input  wire atd_status_t status,
    output atd_cmd_t         cmd
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_CHECK = 15'b000000000000010,
        S_SQ    = 15'b000000000000100,
        S_SQI   = 15'b000000000001000,
        S_SQRT  = 15'b000000000010000,
        S_LEN   = 15'b000000000100000,
        S_DINIT = 15'b000000001000000,
        S_DSTEP = 15'b000000010000000,
        S_DSAVE = 15'b000000100000000,
        S_CINIT = 15'b000001000000000,
        S_CSQRT = 15'b000010000000000,
        S_AINIT = 15'b000100000000000,
        S_ASTEP = 15'b001000000000000,
        S_ASAVE = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] elem_reg, elem_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       fire;

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = in_valid && in_ready;

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= 2'd0;
            col_reg   <= 2'd0;
            elem_reg  <= 2'd0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            col_reg   <= col_next;
            elem_reg  <= elem_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sequencing of the shared datapath
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        col_next   = col_reg;
        elem_next  = elem_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NOP;
        cmd.col    = col_reg;
        cmd.elem   = elem_reg;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire && in_last)
                begin
                    cmd.op     = OP_CAPTURE;
                    count_next = 2'd0;
                    state_next = S_CHECK;
                end
                else if (fire && count_reg != 2'd3)
                begin
                    cmd.op     = OP_STORE;
                    cmd.col    = count_reg;
                    count_next = count_reg + 2'd1;
                end
            end
            S_CHECK:
            begin
                col_next  = 2'd0;
                elem_next = 2'd0;
                state_next = status.invalid ? S_OUT : S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ_ACC;
                if (elem_reg == 2'd2)
                begin
                    elem_next  = 2'd0;
                    state_next = S_SQI;
                end
                else
                begin
                    elem_next = elem_reg + 2'd1;
                end
            end
            S_SQI:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = 5'd0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.op = OP_LEN_SAVE;
                if (col_reg == 2'd2)
                begin
                    col_next   = 2'd0;
                    state_next = S_DINIT;
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = S_SQ;
                end
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = 5'd0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_DSAVE;
                end
            end
            S_DSAVE:
            begin
                cmd.op = OP_DIV_SAVE;
                if (elem_reg != 2'd2)
                begin
                    elem_next  = elem_reg + 2'd1;
                    state_next = S_DINIT;
                end
                else if (col_reg != 2'd2)
                begin
                    elem_next  = 2'd0;
                    col_next   = col_reg + 2'd1;
                    state_next = S_DINIT;
                end
                else
                begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cmd.op     = OP_COS_INIT;
                cnt_next   = 5'd0;
                state_next = S_CSQRT;
            end
            S_CSQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    col_next   = ANG_Y;
                    state_next = S_AINIT;
                end
            end
            S_AINIT:
            begin
                cmd.op     = OP_ATAN_INIT;
                cnt_next   = 5'd0;
                state_next = S_ASTEP;
            end
            S_ASTEP:
            begin
                cmd.op   = OP_ATAN_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = S_ASAVE;
                end
            end
            S_ASAVE:
            begin
                cmd.op = OP_ATAN_SAVE;
                if (col_reg == ANG_Z)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = S_AINIT;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a last column always leads to the w check with an empty store count
    a_capture_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_CAPTURE |=> state_reg == S_CHECK && count_reg == 2'd0)
        else $error("last column did not start the w check");

    // a result is never loaded over one still waiting downstream
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> !status.out_busy)
        else $error("result loaded while output register busy");

    // divider and cordic loops stay within their step count
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTEP || state_reg == S_ASTEP) |-> cnt_reg <= DIV_LAST)
        else $error("iteration counter overran");

    // the w check goes either to the result or to the length pass
    a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |=> state_reg == S_OUT || state_reg == S_SQ)
        else $error("w check left to an unexpected state");

endmodule

`default_nettype wire

### src/atd_dp.sv
`default_nettype none

module atd_dp
    import atd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire atd_cmd_t     cmd,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic [127:0] in_data,
    output atd_status_t       status,
    input  wire logic         out_ready,
    output logic              out_valid,
    output logic [287:0]      out_data,
    output logic              out_flag
);

    logic [15:0]        w_eps_reg;
    logic [95:0]        store_reg [3];
    logic [95:0]        pos_reg;
    logic               invalid_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        root_reg;
    logic [31:0]        len_reg [3];
    logic [32:0]        r_reg;
    logic [29:0]        q_reg;
    logic               dsign_reg, dzero_reg, dfull_reg;
    logic signed [31:0] n_reg [9];
    logic signed [34:0] cx_reg, cy_reg, cz_reg, coff_reg;
    logic               czero_reg;
    logic [31:0]        rot_reg [3];
    logic               out_valid_reg;
    logic [287:0]       out_data_reg;
    logic               out_flag_reg;

    logic [95:0]        row;
    logic signed [31:0] elem_val;
    logic [31:0]        elem_abs;
    logic [63:0]        sq;
    logic signed [32:0] w_ext, w_abs;
    logic               w_small;
    logic [4:0]         k;
    logic [63:0]        sbit, trial;
    logic [31:0]        cur_len;
    logic [32:0]        r2, len33;
    logic [3:0]         n_idx;
    logic [31:0]        nmag;
    logic signed [31:0] s_neg;
    logic signed [63:0] s_ext, ss;
    logic               gimbal;
    logic signed [31:0] ay, ax;
    logic signed [34:0] ay35, ax35, tval, dx, dy, ang, amag, ardd, q29;
    logic [34:0]        rnd;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eps_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            w_eps_reg <= cfg_wdata;
        end
    end

    // stored element and its magnitude
    always_comb
    begin
        row = store_reg[cmd.col];
        case (cmd.elem)
            2'd0:    elem_val = row[31:0];
            2'd1:    elem_val = row[63:32];
            default: elem_val = row[95:64];
        endcase
        elem_abs = elem_val[31] ? 32'(-elem_val) : 32'(elem_val);
        sq       = 64'(elem_abs) * 64'(elem_abs);
    end

    // w magnitude check
    assign w_ext   = {in_data[127], in_data[127:96]};
    assign w_abs   = w_ext[32] ? -w_ext : w_ext;
    assign w_small = w_abs <= $signed({17'd0, w_eps_reg});

    // square root step, bit pair k from the top down
    assign k     = ~cmd.step;
    assign sbit  = 64'd1 << {k, 1'b0};
    assign trial = root_reg + sbit;

    // restoring division step
    assign cur_len = len_reg[cmd.col];
    assign r2      = {r_reg[31:0], 1'b0};
    assign len33   = {1'b0, cur_len};
    assign n_idx   = 4'(cmd.col) * 4'd3 + 4'(cmd.elem);
    assign nmag    = dzero_reg ? 32'd0 : (dfull_reg ? ONE_Q30 : {2'd0, q_reg});

    // pitch cosine input and gimbal test
    assign s_neg  = -n_reg[2];
    assign s_ext  = 64'(s_neg);
    assign ss     = s_ext * s_ext;
    assign gimbal = (n_reg[2] == ONE_Q30) || (n_reg[2] == -ONE_Q30);

    // atan2 operand selection
    always_comb
    begin
        case (cmd.col)
            ANG_Y:
            begin
                ay = s_neg;
                ax = $signed(root_reg[31:0]);
            end
            ANG_X:
            begin
                ay = gimbal ? -n_reg[6] : n_reg[5];
                ax = gimbal ? n_reg[4] : n_reg[8];
            end
            default:
            begin
                ay = n_reg[1];
                ax = n_reg[0];
            end
        endcase
        ay35 = 35'(ay);
        ax35 = 35'(ax);
    end

    // cordic rotation terms and rounding to q3.29
    always_comb
    begin
        tval = $signed({5'd0, atd_atan(cmd.step)});
        dx   = cy_reg >>> cmd.step;
        dy   = cx_reg >>> cmd.step;
        ang  = cz_reg + coff_reg;
        amag = ang[34] ? -ang : ang;
        ardd = (amag + 35'sd1) >>> 1;
        rnd  = (35'(ardd) > ANGLE_MAX_Q29) ? ANGLE_MAX_Q29 : 35'(ardd);
        q29  = ang[34] ? -$signed(rnd) : $signed(rnd);
    end

    // datapath operations
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_STORE:
            begin
                store_reg[cmd.col] <= in_data[95:0];
            end
            OP_CAPTURE:
            begin
                pos_reg     <= in_data[95:0];
                invalid_reg <= w_small;
            end
            OP_SQ_ACC:
            begin
                acc_reg <= ((cmd.elem == 2'd0) ? 64'd0 : acc_reg) + sq;
            end
            OP_SQRT_INIT:
            begin
                rem_reg  <= acc_reg;
                root_reg <= 64'd0;
            end
            OP_SQRT_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + sbit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_LEN_SAVE:
            begin
                len_reg[cmd.col] <= root_reg[31:0];
            end
            OP_DIV_INIT:
            begin
                dsign_reg <= elem_val[31];
                dzero_reg <= (cur_len == 32'd0);
                dfull_reg <= (elem_abs >= cur_len);
                r_reg     <= {1'b0, elem_abs};
                q_reg     <= 30'd0;
            end
            OP_DIV_STEP:
            begin
                if (r2 >= len33)
                begin
                    r_reg <= r2 - len33;
                    q_reg <= {q_reg[28:0], 1'b1};
                end
                else
                begin
                    r_reg <= r2;
                    q_reg <= {q_reg[28:0], 1'b0};
                end
            end
            OP_DIV_SAVE:
            begin
                n_reg[n_idx] <= dsign_reg ? -$signed(nmag) : $signed(nmag);
            end
            OP_COS_INIT:
            begin
                rem_reg  <= ONE_Q60 - 64'(ss);
                root_reg <= 64'd0;
            end
            OP_ATAN_INIT:
            begin
                czero_reg <= (ay == 32'sd0) && (ax == 32'sd0);
                cz_reg    <= 35'sd0;
                if (ax[31])
                begin
                    coff_reg <= ay[31] ? -PI_Q30 : PI_Q30;
                    cx_reg   <= -ax35;
                    cy_reg   <= -ay35;
                end
                else
                begin
                    coff_reg <= 35'sd0;
                    cx_reg   <= ax35;
                    cy_reg   <= ay35;
                end
            end
            OP_ATAN_STEP:
            begin
                if (cy_reg > 35'sd0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + tval;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - tval;
                end
            end
            OP_ATAN_SAVE:
            begin
                if (cmd.col == ANG_Y && gimbal)
                begin
                    rot_reg[ANG_Y] <= n_reg[2][31] ? HALF_PI_Q29 : -HALF_PI_Q29;
                end
                else if ((cmd.col == ANG_Z && gimbal) || czero_reg)
                begin
                    rot_reg[cmd.col] <= 32'd0;
                end
                else
                begin
                    rot_reg[cmd.col] <= q29[31:0];
                end
            end
            OP_OUT:
            begin
                out_flag_reg <= !invalid_reg;
                if (invalid_reg)
                begin
                    out_data_reg <= 288'd0;
                end
                else
                begin
                    // lengths stay below 2^32, so they are packed without saturation
                    out_data_reg <= {rot_reg[ANG_Z], rot_reg[ANG_Y], rot_reg[ANG_X],
                                     len_reg[2], len_reg[1], len_reg[0], pos_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status    = '{invalid: invalid_reg, out_busy: out_valid_reg && !out_ready};
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_flag  = out_flag_reg;

endmodule

`default_nettype wire

### src/affine_transform_decompose.sv
// non-last columns are taken in one per cycle while idle and only stored
// a last column's result reaches the output register after a bit-serial square
// root, a restoring divider and a 30-step cordic shared over three lengths, nine
// normalized terms and three angles, or straight after the w check when w is
// within epsilon; no column is taken until then, longer while a result is held
// reset is asynchronous active low: column count 0, w_epsilon 0, no result
`default_nettype none

module affine_transform_decompose
    import atd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,      // w_epsilon
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // col_x, col_y, col_z, col_w
    input  wire logic         s_axis_tlast,   // last_column
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, rot_x, rot_y, rot_z
    output logic [287:0]      m_axis_tdata,
    output logic [0:0]        m_axis_tuser    // result_valid
);

    atd_cmd_t    cmd;
    atd_status_t status;
    logic        flag;

    // controller
    atd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    atd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_flag  (flag)
    );

    assign m_axis_tuser = flag;

endmodule

`default_nettype wire
